// ----- rtl/mfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mfd_pkg
// Types, register indexes and helpers for the motor feedback decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_ANGLE = 7'b0000010,
    S_FRAC  = 7'b0000100,
    S_QUOT  = 7'b0001000,
    S_SPEED = 7'b0010000,
    S_LIN   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  localparam logic [2:0] REG_ENC_COUNTS = 3'd0;
  localparam logic [2:0] REG_SPEED_A    = 3'd1;
  localparam logic [2:0] REG_CURRENT_A  = 3'd2;
  localparam logic [2:0] REG_GEAR       = 3'd3;
  localparam logic [2:0] REG_LEN_COUNT  = 3'd4;
  localparam logic [2:0] REG_RADIUS     = 3'd5;
  localparam logic [2:0] REG_TEMP_LIMIT = 3'd6;

  // a setup step, then one quotient / partial product bit per cycle
  localparam logic [5:0]  LAST_STEP = 6'd32;
  localparam logic [16:0] COEF_ONE  = 17'd65536;
  localparam logic [22:0] ANGLE_MAX = 23'h7FFFFF;
  localparam logic [47:0] MAX48     = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] MIN48     = 48'h8000_0000_0000;

  function automatic logic [47:0] sat48(input logic signed [65:0] v);
    logic [47:0] r;
    if (v[65:47] == {19{v[47]}}) begin
      r = v[47:0];
    end else if (v[65]) begin
      r = MIN48;
    end else begin
      r = MAX48;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/motor_feedback_decoder_top.sv -----
// ----------------------------------------------------------------------------
// motor_feedback_decoder_top
// Decodes one motor feedback word into multi-turn position, angles, travel,
// smoothed speed and current, and an enabled flag.
// ----------------------------------------------------------------------------
// A word is accepted only while the block is in idle, so a new word is not taken
// until the last one has been handed to the output register. The work is done
// by a bit-serial divider and a bit-serial shift-add multiplier: five passes of
// a setup step plus 32 one-bit steps, with the multiplier running beside the
// divider where the data allows, then a hand-off of the result to the output
// register. A finished result waits in the output register while the next word
// is taken.
`default_nettype none

module motor_feedback_decoder_top
  import mfd_pkg::*;
(
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire  [2:0]         cfg_index,
  input  wire  [31:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire  [15:0]        rotor_position,
  input  wire  signed [15:0] rotor_rpm,
  input  wire  signed [15:0] phase_current,
  input  wire  [7:0]         temperature,
  output logic               out_valid,
  input  wire                out_stall,
  output logic [22:0]        single_turn_angle,
  output logic signed [31:0] turn_count,
  output logic signed [47:0] total_turns,
  output logic signed [47:0] accum_angle,
  output logic signed [47:0] travel_length,
  output logic signed [31:0] speed_dps,
  output logic signed [31:0] output_speed,
  output logic signed [47:0] rim_speed,
  output logic signed [23:0] current_filtered,
  output logic               drive_enable
);

  logic [15:0] encoder_counts;
  logic [16:0] speed_smooth;
  logic [16:0] current_smooth;
  logic [7:0]  gear_div;
  logic [31:0] length_per_count;
  logic [31:0] wheel_radius;
  logic [7:0]  temp_limit;

  state_t      state;
  logic [5:0]  cnt;
  logic        seen_first;
  logic        enabled_flag;
  logic [15:0] prev_position;
  logic [31:0] count_accum;
  logic [31:0] speed_avg;
  logic [23:0] current_avg;

  logic [15:0] pos_r;
  logic [15:0] rpm_r;
  logic [15:0] cur_r;
  logic [22:0] angle_r;
  logic [47:0] travel_r;
  logic [31:0] frac_r;
  logic [47:0] turns_r;
  logic signed [56:0] tang_acc;
  logic [31:0] outspd_r;

  logic [15:0] div_rem;
  logic [31:0] div_quo;
  logic [15:0] div_den;
  logic [16:0] div_sh;
  logic        div_ge;
  logic [16:0] div_sub;

  logic [33:0] mul_hi;
  logic [31:0] mul_lo;
  logic [32:0] mul_cand;
  logic        mul_neg;
  logic [33:0] mul_sum;
  logic [65:0] mul_prod;
  logic signed [65:0] mul_sp;
  logic signed [65:0] lin_sh;

  logic        accept;
  logic [15:0] n_eff;
  logic [7:0]  g_eff;
  logic [16:0] a_spd;
  logic [16:0] a_cur;
  logic signed [17:0] step_diff;
  logic signed [17:0] step_two;
  logic signed [17:0] n_s;
  logic signed [17:0] step_d;
  logic [31:0] count_next;
  logic [31:0] angle_num;
  logic [31:0] count_mag;
  logic [31:0] speed_mag;
  logic signed [33:0] dspd;
  logic [33:0] dspd_mag;
  logic signed [25:0] dcur;
  logic [25:0] dcur_mag;
  logic [31:0] quo_signed_cnt;
  logic signed [56:0] turns_x;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  assign n_eff = (encoder_counts < 16'd2) ? 16'd2 : encoder_counts;
  assign g_eff = (gear_div == 8'd0) ? 8'd1 : gear_div;
  assign a_spd = (speed_smooth > COEF_ONE) ? COEF_ONE : speed_smooth;
  assign a_cur = (current_smooth > COEF_ONE) ? COEF_ONE : current_smooth;

  always_comb begin
    step_diff = $signed({2'b00, rotor_position}) - $signed({2'b00, prev_position});
    step_two  = step_diff <<< 1;
    n_s       = $signed({2'b00, n_eff});
    if (!seen_first) begin
      step_d = '0;
    end else if (step_two > n_s) begin
      step_d = step_diff - n_s;
    end else if (step_two < -n_s) begin
      step_d = step_diff + n_s;
    end else begin
      step_d = step_diff;
    end
  end

  assign count_next = count_accum + {{14{step_d[17]}}, step_d};

  // pos * 46080 = pos * 45 * 1024
  assign angle_num = {1'b0, pos_r, 15'b0} + {3'b0, pos_r, 13'b0}
                   + {4'b0, pos_r, 12'b0} + {6'b0, pos_r, 10'b0};

  assign count_mag = count_accum[31] ? (32'd0 - count_accum) : count_accum;
  assign speed_mag = speed_avg[31] ? (32'd0 - speed_avg) : speed_avg;

  assign dspd = $signed({{8{rpm_r[15]}}, rpm_r, 10'b0})
              + $signed({{9{rpm_r[15]}}, rpm_r, 9'b0})
              - $signed({{2{speed_avg[31]}}, speed_avg});
  assign dspd_mag = dspd[33] ? (34'd0 - dspd) : dspd;

  assign dcur = $signed({{2{cur_r[15]}}, cur_r, 8'b0})
              - $signed({{2{current_avg[23]}}, current_avg});
  assign dcur_mag = dcur[25] ? (26'd0 - dcur) : dcur;

  assign quo_signed_cnt = count_accum[31] ? (32'd0 - div_quo) : div_quo;
  assign turns_x = $signed({{9{turns_r[47]}}, turns_r});

  // restoring divider step
  assign div_sh  = {div_rem, div_quo[31]};
  assign div_ge  = (div_sh >= {1'b0, div_den});
  assign div_sub = div_sh - {1'b0, div_den};

  // shift-add multiplier step
  assign mul_sum  = mul_lo[0] ? ({1'b0, mul_hi[32:0]} + {1'b0, mul_cand})
                              : {1'b0, mul_hi[32:0]};
  assign mul_prod = {mul_hi, mul_lo};
  assign mul_sp   = mul_neg ? $signed(66'd0 - mul_prod) : $signed(mul_prod);
  assign lin_sh   = mul_sp >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      encoder_counts   <= 16'd8192;
      speed_smooth     <= 17'd32768;
      current_smooth   <= 17'd32768;
      gear_div         <= 8'd19;
      length_per_count <= 32'd65536;
      wheel_radius     <= 32'd65536;
      temp_limit       <= 8'd60;
      state            <= S_IDLE;
      cnt              <= '0;
      out_valid        <= 1'b0;
      seen_first       <= 1'b0;
      enabled_flag     <= 1'b0;
      prev_position    <= '0;
      count_accum      <= '0;
      speed_avg        <= '0;
      current_avg      <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_ENC_COUNTS: encoder_counts   <= cfg_data[15:0];
          REG_SPEED_A:    speed_smooth     <= cfg_data[16:0];
          REG_CURRENT_A:  current_smooth   <= cfg_data[16:0];
          REG_GEAR:       gear_div         <= cfg_data[7:0];
          REG_LEN_COUNT:  length_per_count <= cfg_data;
          REG_RADIUS:     wheel_radius     <= cfg_data;
          REG_TEMP_LIMIT: temp_limit       <= cfg_data[7:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      if (cnt != 6'd0) begin
        div_rem <= div_ge ? div_sub[15:0] : div_sh[15:0];
        div_quo <= {div_quo[30:0], div_ge};
        mul_hi  <= {1'b0, mul_sum[33:1]};
        mul_lo  <= {mul_sum[0], mul_lo[31:1]};
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            pos_r         <= rotor_position;
            rpm_r         <= rotor_rpm;
            cur_r         <= phase_current;
            prev_position <= rotor_position;
            seen_first    <= 1'b1;
            count_accum   <= count_next;
            enabled_flag  <= (temperature > temp_limit) ? 1'b0
                           : (seen_first ? enabled_flag : 1'b1);
            cnt           <= '0;
            state         <= S_ANGLE;
          end
        end
        S_ANGLE: begin
          if (cnt == 6'd0) begin
            div_quo  <= angle_num;
            div_rem  <= '0;
            div_den  <= n_eff;
            mul_hi   <= '0;
            mul_lo   <= length_per_count;
            mul_cand <= {1'b0, count_mag};
            mul_neg  <= count_accum[31];
          end
          if (cnt == LAST_STEP) begin
            cnt   <= '0;
            state <= S_FRAC;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_FRAC: begin
          if (cnt == 6'd0) begin
            angle_r  <= (div_quo[31:23] != 9'd0) ? ANGLE_MAX : div_quo[22:0];
            travel_r <= sat48(mul_sp);
            div_quo  <= {pos_r, 16'b0};
            div_rem  <= '0;
            div_den  <= n_eff;
            mul_hi   <= '0;
            mul_lo   <= {15'b0, a_spd};
            mul_cand <= dspd_mag[32:0];
            mul_neg  <= dspd[33];
          end
          if (cnt == LAST_STEP) begin
            cnt   <= '0;
            state <= S_QUOT;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_QUOT: begin
          if (cnt == 6'd0) begin
            frac_r    <= div_quo;
            speed_avg <= speed_avg + mul_sp[47:16];
            div_quo   <= count_mag;
            div_rem   <= '0;
            div_den   <= n_eff;
            mul_hi    <= '0;
            mul_lo    <= {15'b0, a_cur};
            mul_cand  <= {7'b0, dcur_mag};
            mul_neg   <= dcur[25];
          end
          if (cnt == LAST_STEP) begin
            cnt   <= '0;
            state <= S_SPEED;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SPEED: begin
          unique case (cnt)
            6'd0: begin
              turns_r     <= {quo_signed_cnt, 16'b0} + {16'b0, frac_r};
              current_avg <= current_avg + mul_sp[39:16];
              div_quo     <= speed_mag;
              div_rem     <= '0;
              div_den     <= {8'b0, g_eff};
            end
            // turns * 360 = turns * (256 + 64 + 32 + 8)
            6'd1: tang_acc <= turns_x <<< 8;
            6'd2: tang_acc <= tang_acc + (turns_x <<< 6);
            6'd3: tang_acc <= tang_acc + (turns_x <<< 5);
            6'd4: tang_acc <= tang_acc + (turns_x <<< 3);
            default: ;
          endcase
          if (cnt == LAST_STEP) begin
            cnt   <= '0;
            state <= S_LIN;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_LIN: begin
          if (cnt == 6'd0) begin
            outspd_r <= speed_avg[31] ? (32'd0 - div_quo) : div_quo;
            mul_hi   <= '0;
            mul_lo   <= wheel_radius;
            mul_cand <= {1'b0, div_quo};
            mul_neg  <= speed_avg[31];
          end
          if (cnt == LAST_STEP) begin
            cnt   <= '0;
            state <= S_DONE;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            single_turn_angle <= angle_r;
            turn_count        <= count_accum;
            total_turns       <= turns_r;
            accum_angle       <= tang_acc[56:9];
            travel_length     <= travel_r;
            speed_dps         <= speed_avg;
            output_speed      <= outspd_r;
            rim_speed         <= sat48(lin_sh);
            current_filtered  <= current_avg;
            drive_enable      <= enabled_flag;
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_ANGLE && cnt == 6'd0))
    else $error("accepted word did not start the sequence");

  a_count_before_first: assert property (@(posedge clk) disable iff (rst)
    !seen_first |-> (count_accum == 32'd0))
    else $error("count moved before the first word");

  a_done_delivers: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(out_valid && out_stall)) |=> (out_valid && state == S_IDLE))
    else $error("finished result not delivered");

endmodule

`default_nettype wire
